>>> hdl/acbc_pkg.sv
`default_nettype none
package acbc_pkg;

    localparam int unsigned ROUNDS = 10;
    localparam int unsigned RIDX_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYS,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_DECRYPT  = 2'd2
    } t_reg_index;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    // Round constants for rounds 1 to 10; entry 0 is unused.
    localparam logic [7:0] RCON [16] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
        8'h80,8'h1B,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

endpackage
`default_nettype wire

>>> hdl/acbc_in_if.sv
`default_nettype none
interface acbc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        last_block;

    modport source (output valid, block_high, block_low, first_block, last_block,
                    input ready);
    modport sink   (input valid, block_high, block_low, first_block, last_block,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/acbc_out_if.sv
`default_nettype none
interface acbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        result_last;

    modport source (output valid, result_high, result_low, result_last, input ready);
    modport sink   (input valid, result_high, result_low, result_last, output ready);
endinterface
`default_nettype wire

>>> hdl/acbc_round.sv
`default_nettype none
// One cipher round, forward or inverse. Byte k of the state sits at bits 127-8k.
module acbc_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_rkey,
    input  wire logic         i_inverse,
    input  wire logic         i_last,
    output logic      [127:0] o_state
);
    logic [7:0] sb [16];
    logic [7:0] sh [16];
    logic [7:0] ak [16];
    logic [7:0] mx [16];
    logic [127:0] sh_w;
    logic [127:0] ak_w;

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            sb[k] = i_inverse ? acbc_pkg::INV_SBOX[i_state[127-8*k -: 8]]
                              : acbc_pkg::FWD_SBOX[i_state[127-8*k -: 8]];
        end
        // Row r of column c moves by r columns; substitution commutes with it.
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_inverse) begin
                    sh[((c + r) % 4) * 4 + r] = sb[c * 4 + r];
                end else begin
                    sh[c * 4 + r] = sb[((c + r) % 4) * 4 + r];
                end
            end
        end
        for (int k = 0; k < 16; k++) begin
            sh_w[127-8*k -: 8] = sh[k];
        end
        // Forward: mix then add key. Inverse: add key then mix.
        ak_w = i_inverse ? (sh_w ^ i_rkey) : sh_w;
        for (int k = 0; k < 16; k++) begin
            ak[k] = ak_w[127-8*k -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                logic [7:0] a0, a1, a2, a3, x1, x2, x3;
                a0 = ak[c * 4 + r];
                a1 = ak[c * 4 + (r + 1) % 4];
                a2 = ak[c * 4 + (r + 2) % 4];
                a3 = ak[c * 4 + (r + 3) % 4];
                if (i_inverse) begin
                    // 0E a0 ^ 0B a1 ^ 0D a2 ^ 09 a3
                    x1 = acbc_pkg::xtime(a0 ^ a1);
                    x2 = acbc_pkg::xtime(acbc_pkg::xtime(a0 ^ a2));
                    x3 = acbc_pkg::xtime(acbc_pkg::xtime(acbc_pkg::xtime(
                             a0 ^ a1 ^ a2 ^ a3)));
                    mx[c * 4 + r] = x3 ^ x2 ^ x1 ^ a1 ^ a2 ^ a3;
                end else begin
                    x1 = acbc_pkg::xtime(a0 ^ a1);
                    x2 = 8'h00;
                    x3 = 8'h00;
                    mx[c * 4 + r] = x1 ^ a1 ^ a2 ^ a3 ^ x2 ^ x3;
                end
            end
        end
        for (int k = 0; k < 16; k++) begin
            o_state[127-8*k -: 8] = i_last ? ak[k] : mx[k];
        end
        if (!i_inverse) begin
            o_state = o_state ^ i_rkey;
        end
    end
endmodule
`default_nettype wire

>>> hdl/acbc_keysched.sv
`default_nettype none
// Expands the key one round key per cycle and holds all eleven round keys.
module acbc_keysched (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_key,
    input  wire logic [acbc_pkg::RIDX_W-1:0] i_rd_idx,
    output logic      [127:0] o_rd_key,
    output logic              o_done
);
    logic [127:0] r_rk [acbc_pkg::ROUNDS+1];
    logic [127:0] r_kcur;
    logic [acbc_pkg::RIDX_W-1:0] r_cnt;
    logic r_busy;
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    logic [127:0] n_key;

    always_comb begin
        t = {acbc_pkg::FWD_SBOX[r_kcur[23:16]], acbc_pkg::FWD_SBOX[r_kcur[15:8]],
             acbc_pkg::FWD_SBOX[r_kcur[7:0]],   acbc_pkg::FWD_SBOX[r_kcur[31:24]]}
            ^ {acbc_pkg::RCON[r_cnt], 24'h000000};
        w0 = r_kcur[127:96] ^ t;
        w1 = r_kcur[95:64] ^ w0;
        w2 = r_kcur[63:32] ^ w1;
        w3 = r_kcur[31:0] ^ w2;
        n_key = {w0, w1, w2, w3};
    end

    assign o_done   = r_busy && (r_cnt == acbc_pkg::RIDX_W'(acbc_pkg::ROUNDS));
    assign o_rd_key = r_rk[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= acbc_pkg::RIDX_W'(1);
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kcur   <= i_key;
            r_rk[0]  <= i_key;
        end else if (r_busy) begin
            r_kcur       <= n_key;
            r_rk[r_cnt]  <= n_key;
        end
    end
endmodule
`default_nettype wire

>>> hdl/aes128_cbc_cipher_core.sv
`default_nettype none
// Channel  | Dir | Payload                                       | Accepted when
// i_in     | in  | block_high, block_low, first_block, last_block | valid && ready
// o_out    | out | result_high, result_low, result_last           | valid && ready
// i_cfg_*  | in  | index, 64-bit data (key halves, decrypt mode)   | i_cfg_we high
//
// On accept an item gets the first round key and, when encrypting, the chaining
// value; one shared round unit then runs ten rounds, one per cycle, and a final
// step loads the output register, XORing in the chaining value when decrypting.
// The next item is taken while a result still waits. After reset and after each
// key write the key schedule runs, one round key per cycle; no item is accepted
// meanwhile. Reset is synchronous, active low; chaining and key reset to zero.
module aes128_cbc_cipher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    acbc_in_if.sink          i_in,
    acbc_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    acbc_pkg::t_state r_state, n_state;

    logic [127:0] r_key;
    logic         r_decrypt;
    logic         r_kdirty;
    logic [127:0] r_chain;
    logic [127:0] r_data;
    logic [127:0] r_xor;
    logic         r_dec;
    logic         r_last;
    logic [acbc_pkg::RIDX_W-1:0] r_round;
    logic         r_ov;
    logic [127:0] r_res;
    logic         r_res_last;

    logic         ks_start;
    logic         ks_done;
    logic [acbc_pkg::RIDX_W-1:0] rd_idx;
    logic [127:0] rkey;
    logic [127:0] rnd_out;
    logic         in_acc;
    logic         out_load;
    logic         key_wr;
    logic [127:0] blk;
    logic [127:0] chain_eff;

    assign blk       = {i_in.block_high, i_in.block_low};
    assign chain_eff = i_in.first_block ? r_key : r_chain;
    assign i_in.ready = (r_state == acbc_pkg::ST_IDLE) && !r_kdirty;
    assign in_acc    = i_in.valid && i_in.ready;
    assign ks_start  = (r_state == acbc_pkg::ST_IDLE) && r_kdirty;
    assign out_load  = (r_state == acbc_pkg::ST_DONE) && (!r_ov || o_out.ready);
    assign key_wr    = i_cfg_we && ((i_cfg_index == acbc_pkg::REG_KEY_HIGH)
                                 || (i_cfg_index == acbc_pkg::REG_KEY_LOW));

    // The round index counts 1..10; decryption walks the keys from the top down.
    always_comb begin
        if (r_state == acbc_pkg::ST_IDLE) begin
            rd_idx = r_decrypt ? acbc_pkg::RIDX_W'(acbc_pkg::ROUNDS) : '0;
        end else if (r_dec) begin
            rd_idx = acbc_pkg::RIDX_W'(acbc_pkg::ROUNDS) - r_round;
        end else begin
            rd_idx = r_round;
        end
    end

    acbc_keysched u_keysched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ks_start),
        .i_key    (r_key),
        .i_rd_idx (rd_idx),
        .o_rd_key (rkey),
        .o_done   (ks_done)
    );

    acbc_round u_round (
        .i_state   (r_data),
        .i_rkey    (rkey),
        .i_inverse (r_dec),
        .i_last    (r_round == acbc_pkg::RIDX_W'(acbc_pkg::ROUNDS)),
        .o_state   (rnd_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            acbc_pkg::ST_IDLE: begin
                if (ks_start) begin
                    n_state = acbc_pkg::ST_KEYS;
                end else if (in_acc) begin
                    n_state = acbc_pkg::ST_RUN;
                end
            end
            acbc_pkg::ST_KEYS: begin
                if (ks_done) begin
                    n_state = acbc_pkg::ST_IDLE;
                end
            end
            acbc_pkg::ST_RUN: begin
                if (r_round == acbc_pkg::RIDX_W'(acbc_pkg::ROUNDS)) begin
                    n_state = acbc_pkg::ST_DONE;
                end
            end
            acbc_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = acbc_pkg::ST_IDLE;
                end
            end
            default: n_state = acbc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers. A key write schedules a fresh key expansion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_decrypt <= 1'b0;
            r_kdirty  <= 1'b1;
        end else begin
            if (key_wr) begin
                r_kdirty <= 1'b1;
            end else if (ks_start) begin
                r_kdirty <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    acbc_pkg::REG_KEY_HIGH: begin
                        r_key[127:64] <= i_cfg_data;
                    end
                    acbc_pkg::REG_KEY_LOW: begin
                        r_key[63:0] <= i_cfg_data;
                    end
                    acbc_pkg::REG_DECRYPT: begin
                        r_decrypt <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Chaining value: reset to zero, updated with the ciphertext of each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (in_acc && r_decrypt) begin
            r_chain <= blk;
        end else if (out_load && !r_dec) begin
            r_chain <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else if (in_acc) begin
            r_round <= acbc_pkg::RIDX_W'(1);
        end else if (r_state == acbc_pkg::ST_RUN) begin
            r_round <= r_round + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dec  <= r_decrypt;
            r_last <= i_in.last_block;
            r_xor  <= chain_eff;
            r_data <= r_decrypt ? (blk ^ rkey) : (blk ^ chain_eff ^ rkey);
        end else if (r_state == acbc_pkg::ST_RUN) begin
            r_data <= rnd_out;
        end
    end

    // Output register; it holds a result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res      <= r_dec ? (r_data ^ r_xor) : r_data;
            r_res_last <= r_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.result_high = r_res[127:64];
    assign o_out.result_low  = r_res[63:0];
    assign o_out.result_last = r_res_last;
endmodule
`default_nettype wire

>>> dv/aes128_cbc_cipher_core_test.sv
`default_nettype none
module aes128_cbc_cipher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 30;

    // One expected cipher output block.
    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } t_cipher_block;

    // A row of the directed table either writes a register or sends a block.
    // Where the row carries a known answer (published AES vectors), that
    // answer is queued instead of the predicted one.
    typedef enum logic {ROW_CFG, ROW_BLOCK} t_row_kind;
    typedef struct {
        t_row_kind            kind;
        acbc_pkg::t_reg_index idx;
        logic [63:0]          hi;
        logic [63:0]          lo;
        logic                 first;
        logic                 last;
        logic                 known;
        logic [63:0]          known_hi;
        logic [63:0]          known_lo;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [63:0] i_cfg_data;

    acbc_in_if  in_if ();
    acbc_out_if out_if ();

    aes128_cbc_cipher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // The clock runs at 50 MHz.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Our own copy of the block's state: the key, the direction, the round key
    // schedule and the CBC chaining value.
    logic [7:0]  sub_fwd [256];
    logic [7:0]  sub_inv [256];
    logic [63:0] key_hi, key_lo;
    logic        decrypting;
    logic [31:0] sched_words [44];
    logic [63:0] chain_hi, chain_lo;

    t_cipher_block cipher_results_q [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count;
    int unsigned blocks_sent;
    int unsigned blocks_checked;
    int unsigned messages_sent;
    int unsigned reg_writes;
    int unsigned mismatches;
    int unsigned failures;

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    // The S-boxes are derived from the field inverse and the affine map,
    // so that a bad table in the design cannot hide behind a copied one.
    task automatic build_sboxes();
        logic [7:0] inv_el, s;
        for (int x = 0; x < 256; x++) begin
            inv_el = 8'h00;
            for (int y = 1; y < 256; y++)
                if (x != 0 && gf_mul(8'(x), 8'(y)) == 8'h01) inv_el = 8'(y);
            s = inv_el ^ {inv_el[6:0], inv_el[7]} ^ {inv_el[5:0], inv_el[7:6]}
                ^ {inv_el[4:0], inv_el[7:5]} ^ {inv_el[3:0], inv_el[7:4]} ^ 8'h63;
            sub_fwd[x] = s;
            sub_inv[s] = 8'(x);
        end
    endtask

    task automatic expand_key();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        sched_words[0] = key_hi[63:32];
        sched_words[1] = key_hi[31:0];
        sched_words[2] = key_lo[63:32];
        sched_words[3] = key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = sched_words[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_fwd[t[31:24]], sub_fwd[t[23:16]], sub_fwd[t[15:8]], sub_fwd[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gf_double(rc);
            end
            sched_words[i] = sched_words[i-4] ^ t;
        end
    endtask

    function automatic void xor_round_key(inout logic [7:0] s [16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[c*4+r] ^= sched_words[rnd*4+c][31-8*r -: 8];
    endfunction

    function automatic void rotate_rows(inout logic [7:0] s [16], input logic inverse);
        logic [7:0] t [16];
        t = s;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (inverse) s[((c+r)%4)*4+r] = t[c*4+r];
                else s[c*4+r] = t[((c+r)%4)*4+r];
    endfunction

    function automatic void blend_columns(inout logic [7:0] s [16], input logic inverse);
        logic [7:0] coef [4];
        logic [7:0] col [4];
        logic [7:0] v;
        if (inverse) coef = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
        else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = s[c*4+r];
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gf_mul(coef[(k-r+4)%4], col[k]);
                s[c*4+r] = v;
            end
        end
    endfunction

    // One block through the cipher in the given direction; byte 0 is the
    // top byte of the 128-bit vector.
    function automatic logic [127:0] run_cipher(input logic [127:0] blk, input logic inverse);
        logic [7:0] s [16];
        logic [127:0] res;
        for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8];
        if (!inverse) begin
            xor_round_key(s, 0);
            for (int rnd = 1; rnd <= 10; rnd++) begin
                for (int k = 0; k < 16; k++) s[k] = sub_fwd[s[k]];
                rotate_rows(s, 1'b0);
                if (rnd != 10) blend_columns(s, 1'b0);
                xor_round_key(s, rnd);
            end
        end else begin
            xor_round_key(s, 10);
            for (int rnd = 9; rnd >= 0; rnd--) begin
                rotate_rows(s, 1'b1);
                for (int k = 0; k < 16; k++) s[k] = sub_inv[s[k]];
                xor_round_key(s, rnd);
                if (rnd != 0) blend_columns(s, 1'b1);
            end
        end
        for (int k = 0; k < 16; k++) res[127-8*k -: 8] = s[k];
        return res;
    endfunction

    // CBC step: works out the result of one accepted block and moves the
    // chaining value on to the newest ciphertext.
    function automatic t_cipher_block cbc_next(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic first, input logic last);
        t_cipher_block res;
        logic [127:0] chain, data;
        if (first) begin
            chain_hi = key_hi;
            chain_lo = key_lo;
        end
        chain = {chain_hi, chain_lo};
        if (decrypting) begin
            data = run_cipher({hi, lo}, 1'b1) ^ chain;
            {chain_hi, chain_lo} = {hi, lo};
        end else begin
            data = run_cipher({hi, lo} ^ chain, 1'b0);
            {chain_hi, chain_lo} = data;
        end
        res.hi = data[127:64];
        res.lo = data[63:0];
        res.last = last;
        return res;
    endfunction

    // Offers one block, with random idle cycles first, and queues its
    // result once the block has been taken.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic first, input logic last,
                              input logic known, input logic [63:0] known_hi,
                              input logic [63:0] known_lo);
        t_cipher_block res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.block_high  <= hi;
        in_if.block_low   <= lo;
        in_if.first_block <= first;
        in_if.last_block  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        res = cbc_next(hi, lo, first, last);
        if (known) begin
            res.hi = known_hi;
            res.lo = known_lo;
        end
        cipher_results_q.push_back(res);
        blocks_sent++;
        if (last) messages_sent++;
    endtask

    // Holds off until every queued result is back and the core has settled.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (cipher_results_q.size() != 0) @(posedge i_clk);
        repeat (14) @(posedge i_clk);
    endtask

    // Register writes happen only when the core is drained. A key write also
    // restarts the key schedule, which the core covers by holding ready low.
    task automatic write_reg(input acbc_pkg::t_reg_index idx, input logic [63:0] data);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            acbc_pkg::REG_KEY_HIGH: begin
                key_hi = data;
                expand_key();
            end
            acbc_pkg::REG_KEY_LOW: begin
                key_lo = data;
                expand_key();
            end
            default: begin
                decrypting = data[0];
            end
        endcase
        reg_writes++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Keys lean toward the extremes now and then, otherwise they are random.
    function automatic logic [63:0] rand_key_half();
        case ($urandom_range(5))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // Receiver side: ready drops at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_cipher_block want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (cipher_results_q.size() == 0) begin
                failures++;
                $display("ERROR: result %h_%h arrived with nothing expected",
                         out_if.result_high, out_if.result_low);
            end else begin
                want = cipher_results_q.pop_front();
                blocks_checked++;
                if (out_if.result_high !== want.hi || out_if.result_low !== want.lo
                    || out_if.result_last !== want.last) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d expected %h_%h last %b, got %h_%h last %b",
                                 blocks_checked, want.hi, want.lo, want.last,
                                 out_if.result_high, out_if.result_low,
                                 out_if.result_last);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: no progress within %0d cycles", CYCLE_LIMIT);
            $display("aes128_cbc_cipher_core_test failed");
            $finish;
        end
    end

    // Directed part. The first block runs with the reset key of all zeros and
    // no first mark, so the chaining value must be the reset key as well; the
    // known answers are the published AES-128 vectors, with the data block
    // pre-XORed by the key because the IV equals the key. The rest covers the
    // extreme keys and data, a key change and a direction change in the middle
    // of a message, and both directions.
    t_row directed [] = '{
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h0, 64'h0, 1'b0, 1'b0,
          1'b1, 64'h66E94BD4EF8A2C3B, 64'h884CFA59CA342B2E},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, '1, '1, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG, acbc_pkg::REG_KEY_HIGH, 64'h0001020304050607, 64'h0, 1'b0, 1'b0,
          1'b0, 64'h0, 64'h0},
        '{ROW_CFG, acbc_pkg::REG_KEY_LOW, 64'h08090A0B0C0D0E0F, 64'h0, 1'b0, 1'b0,
          1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h0010203040506070, 64'h8090A0B0C0D0E0F0,
          1'b1, 1'b0, 1'b1, 64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, '1, '1, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG, acbc_pkg::REG_DECRYPT, 64'h1, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A,
          1'b1, 1'b0, 1'b1, 64'h0010203040506070, 64'h8090A0B0C0D0E0F0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG, acbc_pkg::REG_DECRYPT, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h0123456789ABCDEF, '1, 1'b0, 1'b0,
          1'b0, 64'h0, 64'h0},
        '{ROW_CFG, acbc_pkg::REG_KEY_HIGH, '1, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h0, '1, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG, acbc_pkg::REG_KEY_LOW, '1, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, '1, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h0, 64'h0, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG, acbc_pkg::REG_DECRYPT, 64'h1, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, '1, '1, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'h0, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{ROW_BLOCK, acbc_pkg::REG_KEY_HIGH, 64'hFEDCBA9876543210, 64'h0, 1'b0, 1'b1,
          1'b0, 64'h0, 64'h0}
    };

    initial begin
        int unsigned msg_len;
        int unsigned target;
        logic noisy;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= acbc_pkg::REG_KEY_HIGH;
        i_cfg_data        <= 64'h0;
        in_if.valid       <= 1'b0;
        in_if.block_high  <= 64'h0;
        in_if.block_low   <= 64'h0;
        in_if.first_block <= 1'b0;
        in_if.last_block  <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cycle_count = 0;
        blocks_sent = 0;
        blocks_checked = 0;
        messages_sent = 0;
        reg_writes = 0;
        mismatches = 0;
        failures = 0;

        build_sboxes();
        key_hi = 64'h0;
        key_lo = 64'h0;
        decrypting = 1'b0;
        expand_key();
        chain_hi = key_hi;
        chain_lo = key_lo;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed table runs with light idling on both sides.
        send_idle_pct = 7;
        recv_idle_pct = 20;
        foreach (directed[n]) begin
            if (directed[n].kind == ROW_CFG)
                write_reg(directed[n].idx, directed[n].hi);
            else
                send_block(directed[n].hi, directed[n].lo, directed[n].first,
                           directed[n].last, directed[n].known, directed[n].known_hi,
                           directed[n].known_lo);
        end

        // Random part in three phases of idling. Most traffic is well-formed
        // messages; about one message in ten has random first and last marks.
        // Between messages the key or the direction changes now and then.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Each phase begins with the sender holding off until all
            // outstanding results have come back.
            wait_drained();
            target = blocks_sent + 560;
            while (blocks_sent < target) begin
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(2))
                        0: write_reg(acbc_pkg::REG_KEY_HIGH, rand_key_half());
                        1: write_reg(acbc_pkg::REG_KEY_LOW, rand_key_half());
                        default: write_reg(acbc_pkg::REG_DECRYPT, 64'($urandom_range(1)));
                    endcase
                end
                msg_len = $urandom_range(8, 1);
                noisy = ($urandom_range(9) == 0);
                for (int b = 0; b < msg_len; b++)
                    send_block(rand64(), rand64(),
                               noisy ? 1'($urandom_range(1)) : (b == 0),
                               noisy ? 1'($urandom_range(1)) : (b == msg_len - 1),
                               1'b0, 64'h0, 64'h0);
            end
        end

        in_if.valid <= 1'b0;
        while (cipher_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d blocks (%0d checked) in %0d messages, %0d register writes,",
                 blocks_sent, blocks_checked, messages_sent, reg_writes);
        $display("both CBC directions and three idling patterns; %0d mismatches.", mismatches);
        if (failures == 0 && cipher_results_q.size() == 0) begin
            $display("aes128_cbc_cipher_core_test passed");
        end else begin
            $display("aes128_cbc_cipher_core_test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
hdl/acbc_pkg.sv
hdl/acbc_in_if.sv
hdl/acbc_out_if.sv
hdl/acbc_round.sv
hdl/acbc_keysched.sv
hdl/aes128_cbc_cipher_core.sv
dv/aes128_cbc_cipher_core_test.sv
